### hw/rtl/spi_pwm_pkg.sv
`default_nettype none

package spi_pwm_pkg;

  typedef enum logic [1:0] {
    ACT_SPI  = 2'd0,
    ACT_PIN  = 2'd1,
    ACT_BATT = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    PH_CMD    = 3'd0,
    PH_HIGH   = 3'd1,
    PH_MIRROR = 3'd5,
    PH_DRV_A  = 3'd6,
    PH_DRV_B  = 3'd7
  } phase_e;

  localparam logic [7:0] CMD_TIMER  = 8'h01;
  localparam logic [7:0] CMD_WIDTH  = 8'h02;
  localparam logic [7:0] CMD_MIRROR = 8'h03;
  localparam logic [7:0] CMD_DRIVE  = 8'h04;
  localparam logic [7:0] CMD_BATT   = 8'h05;

  localparam logic       REG_STARTUP   = 1'b0;
  localparam logic [7:0] STARTUP_RESET = 8'd117;

endpackage

`default_nettype wire

### hw/rtl/spi_command_pwm_capture_bridge.sv
// channel   dir  handshake                     payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tuser: action; tdata: spi byte, pins,
//                                              pulse timer, cycle timer, battery
// m_axis    out  m_axis_tvalid/m_axis_tready   tuser: mirror_on; tdata: reply, drives
// apb       in   psel/penable/pwrite/pready    startup_drive at address 0
//
// one word per cycle sustained while m_axis_tready is high; input register, then result register
// the command, capture and mirror logic sits between those two registers
// rst_ni resets all but the payload/result data; drives reset to 117, mirror byte to one
// a stalled result holds in the output register while the input register takes one more
// word, so s_axis_tready only drops when both are full and m_axis_tready is low
`default_nettype none

module spi_command_pwm_capture_bridge
  import spi_pwm_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // spi_byte[7:0], pin_levels[9:8], pulse_timer[17:10], cycle_timer[33:18],
  // battery_sample[43:34], zero fill
  input  wire logic [47:0] s_axis_tdata,
  // action[1:0]
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // reply_byte[7:0], drive_a[15:8], drive_b[23:16]
  output logic [23:0]      m_axis_tdata,
  // mirror_on[0]
  output logic [0:0]       m_axis_tuser,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic        in_valid_q;
  action_e     action_q;
  logic [7:0]  spi_byte_q;
  logic [1:0]  pin_levels_q;
  logic [7:0]  pulse_timer_q;
  logic [15:0] cycle_timer_q;
  logic [9:0]  battery_sample_q;

  logic        out_valid_q;
  logic [23:0] out_data_q;
  logic        out_mirror_q;

  phase_e      phase_q, phase_d;
  logic [7:0]  startup_q;
  logic [7:0]  high_hold_q, high_hold_d;
  logic [7:0]  reply_q, reply_d;
  logic [7:0]  mirror_q, mirror_d;
  logic        level_a_q, level_a_d, level_b_q, level_b_d;
  logic [7:0]  start_a_q, start_a_d, start_b_q, start_b_d;
  logic [7:0]  width_a_q, width_a_d, width_b_q, width_b_d;
  logic [7:0]  drive_a_q, drive_a_d, drive_b_q, drive_b_d;
  logic [9:0]  battery_q, battery_d;

  logic        proc;
  logic        cfg_wr;

  assign proc          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || proc;
  assign cfg_wr        = psel && penable && pwrite && pready && (paddr[2] == REG_STARTUP);
  assign pready        = 1'b1;
  assign prdata        = (paddr[2] == REG_STARTUP) ? {24'd0, startup_q} : 32'd0;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_mirror_q;

  // command phase sequencing
  always_comb begin
    phase_d = phase_q;
    if (action_q == ACT_SPI) begin
      unique case (phase_q)
        PH_HIGH:   phase_d = PH_CMD;
        PH_MIRROR: phase_d = PH_CMD;
        PH_DRV_A:  phase_d = PH_DRV_B;
        PH_DRV_B:  phase_d = PH_CMD;
        default: begin
          unique case (spi_byte_q)
            CMD_TIMER:  phase_d = PH_HIGH;
            CMD_WIDTH:  phase_d = PH_HIGH;
            CMD_MIRROR: phase_d = PH_MIRROR;
            CMD_DRIVE:  phase_d = PH_DRV_A;
            CMD_BATT:   phase_d = PH_HIGH;
            default:    phase_d = PH_CMD;
          endcase
        end
      endcase
    end
  end

  // data path of one word
  always_comb begin
    high_hold_d = high_hold_q;
    reply_d     = reply_q;
    mirror_d    = mirror_q;
    level_a_d   = level_a_q;
    level_b_d   = level_b_q;
    start_a_d   = start_a_q;
    start_b_d   = start_b_q;
    width_a_d   = width_a_q;
    width_b_d   = width_b_q;
    drive_a_d   = drive_a_q;
    drive_b_d   = drive_b_q;
    battery_d   = battery_q;

    case (action_q)
      ACT_SPI: begin
        unique case (phase_q)
          PH_HIGH: reply_d = high_hold_q;
          PH_MIRROR: begin
            mirror_d = spi_byte_q;
            reply_d  = 8'd0;
          end
          PH_DRV_A: begin
            reply_d   = drive_a_q;
            drive_a_d = spi_byte_q;
          end
          PH_DRV_B: begin
            reply_d   = drive_b_q;
            drive_b_d = spi_byte_q;
          end
          default: begin
            unique case (spi_byte_q)
              CMD_TIMER: begin
                reply_d     = cycle_timer_q[7:0];
                high_hold_d = cycle_timer_q[15:8];
              end
              CMD_WIDTH: begin
                reply_d     = width_a_q;
                high_hold_d = width_b_q;
              end
              CMD_MIRROR: reply_d = {mirror_q[6:0], 1'b1};
              CMD_DRIVE:  reply_d = 8'd1;
              CMD_BATT: begin
                reply_d     = battery_q[7:0];
                high_hold_d = {6'd0, battery_q[9:8]};
              end
              default:    reply_d = 8'd0;
            endcase
          end
        endcase
      end
      ACT_PIN: begin
        if (pin_levels_q[0] != level_a_q) begin
          level_a_d = pin_levels_q[0];
          if (pin_levels_q[0]) begin
            start_a_d = pulse_timer_q;
          end else begin
            width_a_d = pulse_timer_q - start_a_q;
          end
        end
        if (pin_levels_q[1] != level_b_q) begin
          level_b_d = pin_levels_q[1];
          if (pin_levels_q[1]) begin
            start_b_d = pulse_timer_q;
          end else begin
            width_b_d = pulse_timer_q - start_b_q;
          end
        end
      end
      ACT_BATT: battery_d = battery_sample_q;
      default: ;
    endcase

    // mirror the captured widths onto the drives
    if (mirror_d != 8'd0 && width_a_d != 8'd0 && width_b_d != 8'd0) begin
      drive_a_d = width_a_d;
      drive_b_d = width_b_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      phase_q      <= PH_CMD;
      startup_q    <= STARTUP_RESET;
      high_hold_q  <= 8'd0;
      reply_q      <= 8'd0;
      mirror_q     <= 8'd1;
      level_a_q    <= 1'b0;
      level_b_q    <= 1'b0;
      start_a_q    <= 8'd0;
      start_b_q    <= 8'd0;
      width_a_q    <= 8'd0;
      width_b_q    <= 8'd0;
      drive_a_q    <= STARTUP_RESET;
      drive_b_q    <= STARTUP_RESET;
      battery_q    <= 10'd0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (proc) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (proc) begin
        phase_q     <= phase_d;
        high_hold_q <= high_hold_d;
        reply_q     <= reply_d;
        mirror_q    <= mirror_d;
        level_a_q   <= level_a_d;
        level_b_q   <= level_b_d;
        start_a_q   <= start_a_d;
        start_b_q   <= start_b_d;
        width_a_q   <= width_a_d;
        width_b_q   <= width_b_d;
        battery_q   <= battery_d;
      end
      if (cfg_wr) begin
        startup_q <= pwdata[7:0];
        drive_a_q <= pwdata[7:0];
        drive_b_q <= pwdata[7:0];
      end else if (proc) begin
        drive_a_q <= drive_a_d;
        drive_b_q <= drive_b_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      action_q         <= action_e'(s_axis_tuser);
      spi_byte_q       <= s_axis_tdata[7:0];
      pin_levels_q     <= s_axis_tdata[9:8];
      pulse_timer_q    <= s_axis_tdata[17:10];
      cycle_timer_q    <= s_axis_tdata[33:18];
      battery_sample_q <= s_axis_tdata[43:34];
    end
    if (proc) begin
      out_data_q   <= {drive_b_d, drive_a_d, reply_d};
      out_mirror_q <= (mirror_d != 8'd0);
    end
  end

  a_phase_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_CMD || phase_q == PH_HIGH || phase_q == PH_MIRROR ||
    phase_q == PH_DRV_A || phase_q == PH_DRV_B)
    else $error("command phase left the legal set");

  a_mirror_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser[0] == (mirror_q != 8'd0)))
    else $error("mirror flag out of step with mirror byte");

  a_mirror_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && mirror_q != 8'd0 && width_a_q != 8'd0 && width_b_q != 8'd0 |->
      m_axis_tdata[15:8] == width_a_q && m_axis_tdata[23:16] == width_b_q)
    else $error("drives do not follow captured widths");

  a_cfg_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr |=> drive_a_q == $past(pwdata[7:0]) && drive_b_q == $past(pwdata[7:0]))
    else $error("startup write did not load drives");

  a_reply_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc |=> m_axis_tdata[7:0] == reply_q)
    else $error("reply byte differs from loaded reply");

endmodule

`default_nettype wire
